// ----- sv/bdq_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and codes for the bounded deque.
// No dependencies; every other file of the block uses it.
package bdq_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int DATA_W       = 32;

    typedef logic [2:0] t_func;
    localparam t_func FUNC_PUSH_FRONT = 3'd0;
    localparam t_func FUNC_PUSH_BACK  = 3'd1;
    localparam t_func FUNC_POP_FRONT  = 3'd2;
    localparam t_func FUNC_POP_BACK   = 3'd3;
    localparam t_func FUNC_DUMP       = 3'd4;

    typedef logic [1:0] t_status;
    localparam t_status ST_OK      = 2'd0;
    localparam t_status ST_FULL    = 2'd1;
    localparam t_status ST_EMPTY   = 2'd2;
    localparam t_status ST_INVALID = 2'd3;

    // command class after decode
    typedef logic [1:0] t_kind;
    localparam t_kind KIND_PUSH = 2'd0;
    localparam t_kind KIND_POP  = 2'd1;
    localparam t_kind KIND_DUMP = 2'd2;
    localparam t_kind KIND_BAD  = 2'd3;

    typedef struct packed {
        t_kind                    kind;
        logic                     at_front;
        logic signed [DATA_W-1:0] data;
    } t_cmd;

endpackage

// ----- sv/bdq_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces: command beats in, result beats out.
// Depends on bdq_pkg.
interface bdq_cmd_if;
    logic                              valid;
    logic                              ready;
    bdq_pkg::t_func                    func;
    logic signed [bdq_pkg::DATA_W-1:0] data_value;

    modport source (output valid, func, data_value, input ready);
    modport sink   (input valid, func, data_value, output ready);
endinterface

interface bdq_res_if;
    logic                              valid;
    logic                              ready;
    bdq_pkg::t_status                  status;
    logic signed [bdq_pkg::DATA_W-1:0] element_value;
    logic                              last_of_run;

    modport source (output valid, status, element_value, last_of_run, input ready);
    modport sink   (input valid, status, element_value, last_of_run, output ready);
endinterface

// ----- sv/bdq_front.sv -----
`timescale 1ns / 1ps
// Front end: takes command beats, decodes them, holds them in a 2-entry queue.
// Depends on bdq_pkg and bdq_cmd_if.
module bdq_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    bdq_cmd_if.sink         i_cmd,
    output bdq_pkg::t_cmd   o_head,
    output logic            o_head_valid,
    input  logic            i_head_pop
);

    bdq_pkg::t_cmd r_q [2];
    logic          r_wr_ptr;
    logic          r_rd_ptr;
    logic [1:0]    r_cnt;
    logic [1:0]    n_cnt;
    bdq_pkg::t_cmd cmd_dec;
    logic          push;
    logic          pop;

    assign i_cmd.ready  = (r_cnt != 2'd2);
    assign push         = i_cmd.valid && i_cmd.ready;
    assign pop          = i_head_pop && (r_cnt != 2'd0);
    assign o_head_valid = (r_cnt != 2'd0);
    assign o_head       = r_q[r_rd_ptr];

    always_comb begin
        cmd_dec.data     = i_cmd.data_value;
        cmd_dec.at_front = 1'b0;
        cmd_dec.kind     = bdq_pkg::KIND_BAD;
        case (i_cmd.func)
            bdq_pkg::FUNC_PUSH_FRONT: begin
                cmd_dec.kind     = bdq_pkg::KIND_PUSH;
                cmd_dec.at_front = 1'b1;
            end
            bdq_pkg::FUNC_PUSH_BACK: begin
                cmd_dec.kind = bdq_pkg::KIND_PUSH;
            end
            bdq_pkg::FUNC_POP_FRONT: begin
                cmd_dec.kind     = bdq_pkg::KIND_POP;
                cmd_dec.at_front = 1'b1;
            end
            bdq_pkg::FUNC_POP_BACK: begin
                cmd_dec.kind = bdq_pkg::KIND_POP;
            end
            bdq_pkg::FUNC_DUMP: begin
                cmd_dec.kind = bdq_pkg::KIND_DUMP;
            end
            default: begin
                cmd_dec.kind = bdq_pkg::KIND_BAD;
            end
        endcase
    end

    always_comb begin
        n_cnt = r_cnt;
        if (push && !pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= cmd_dec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_cnt <= n_cnt;
        end
    end

    q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) |=> (r_cnt != 2'd0))
        else $error("command queue drained by more than one beat per cycle");

endmodule

// ----- sv/bdq_back.sv -----
`timescale 1ns / 1ps
// Back end: ring-buffer store, front pointer and count, dump sequencer, result register.
// Depends on bdq_pkg and bdq_res_if.
module bdq_back #(
    parameter int CAPACITY = bdq_pkg::CAPACITY_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  bdq_pkg::t_cmd i_head,
    input  logic          i_head_valid,
    output logic          o_head_pop,
    bdq_res_if.source     o_res
);

    localparam int PW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SW = PW + 1;
    localparam int DW = bdq_pkg::DATA_W;

    localparam logic [PW-1:0] LAST_SLOT = PW'(CAPACITY - 1);
    localparam logic [CW-1:0] CAP_CNT   = CW'(CAPACITY);
    localparam logic [SW-1:0] CAP_SUM   = SW'(CAPACITY);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_DOUT = 1'b1;

    logic [DW-1:0]    r_mem [CAPACITY];
    logic [DW-1:0]    r_rdata;
    logic             r_state,  n_state;
    logic [PW-1:0]    r_fp,     n_fp;
    logic [CW-1:0]    r_count,  n_count;
    logic [PW-1:0]    r_slot,   n_slot;
    logic [CW-1:0]    r_left,   n_left;

    logic             r_out_valid;
    bdq_pkg::t_status r_out_status;
    logic [DW-1:0]    r_out_elem;
    logic             r_out_last;

    logic             out_free;
    logic             go;
    logic             emit;
    logic             is_full;
    logic             is_empty;
    logic [PW-1:0]    fp_dec;
    logic [PW-1:0]    fp_inc;
    logic [PW-1:0]    slot_inc;
    logic [SW-1:0]    tail_sum;
    logic [PW-1:0]    tail;
    logic             we;
    logic [PW-1:0]    wa;
    logic [PW-1:0]    ra;
    logic             load;
    bdq_pkg::t_status n_status;
    logic [DW-1:0]    n_elem;
    logic             n_last;

    assign out_free = !r_out_valid || o_res.ready;
    assign go       = (r_state == S_IDLE) && i_head_valid && out_free;
    assign emit     = (r_state == S_DOUT) && out_free;
    assign is_full  = (r_count == CAP_CNT);
    assign is_empty = (r_count == '0);

    assign fp_dec   = (r_fp == '0) ? LAST_SLOT : r_fp - 1'b1;
    assign fp_inc   = (r_fp == LAST_SLOT) ? '0 : r_fp + 1'b1;
    assign slot_inc = (r_slot == LAST_SLOT) ? '0 : r_slot + 1'b1;

    // back slot: front + count, always below twice the capacity
    assign tail_sum = SW'(r_fp) + SW'(r_count);
    assign tail     = (tail_sum >= CAP_SUM) ? PW'(tail_sum - CAP_SUM) : PW'(tail_sum);

    always_comb begin
        n_state    = r_state;
        n_fp       = r_fp;
        n_count    = r_count;
        n_slot     = r_slot;
        n_left     = r_left;
        we         = 1'b0;
        wa         = tail;
        ra         = r_slot;
        load       = 1'b0;
        n_status   = bdq_pkg::ST_OK;
        n_elem     = '0;
        n_last     = 1'b1;
        o_head_pop = 1'b0;

        if (go) begin
            case (i_head.kind)
                bdq_pkg::KIND_PUSH: begin
                    load       = 1'b1;
                    o_head_pop = 1'b1;
                    if (is_full) begin
                        n_status = bdq_pkg::ST_FULL;
                    end else begin
                        we      = 1'b1;
                        n_count = r_count + 1'b1;
                        if (i_head.at_front) begin
                            n_fp = fp_dec;
                            wa   = fp_dec;
                        end
                    end
                end
                bdq_pkg::KIND_POP: begin
                    load       = 1'b1;
                    o_head_pop = 1'b1;
                    if (is_empty) begin
                        n_status = bdq_pkg::ST_EMPTY;
                    end else begin
                        n_count = r_count - 1'b1;
                        if (i_head.at_front) begin
                            n_fp = fp_inc;
                        end
                    end
                end
                bdq_pkg::KIND_DUMP: begin
                    if (is_empty) begin
                        load       = 1'b1;
                        o_head_pop = 1'b1;
                        n_status   = bdq_pkg::ST_EMPTY;
                    end else begin
                        ra      = r_fp;
                        n_slot  = r_fp;
                        n_left  = r_count;
                        n_state = S_DOUT;
                    end
                end
                default: begin
                    load       = 1'b1;
                    o_head_pop = 1'b1;
                    n_status   = bdq_pkg::ST_INVALID;
                end
            endcase
        end

        if (emit) begin
            load   = 1'b1;
            n_elem = r_rdata;
            n_last = (r_left == CW'(1));
            if (n_last) begin
                o_head_pop = 1'b1;
                n_state    = S_IDLE;
            end else begin
                n_slot = slot_inc;
                ra     = slot_inc;
                n_left = r_left - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wa] <= i_head.data;
        end
        r_rdata <= r_mem[ra];
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_status <= n_status;
            r_out_elem   <= n_elem;
            r_out_last   <= n_last;
        end
        r_slot <= n_slot;
        r_left <= n_left;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fp        <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fp    <= n_fp;
            r_count <= n_count;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.status        = r_out_status;
    assign o_res.element_value = r_out_elem;
    assign o_res.last_of_run   = r_out_last;

    dump_keeps_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DOUT) |=> ($stable(r_count) && $stable(r_fp)))
        else $error("queue state changed during a dump");

    dump_left_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DOUT) |-> ((r_left != '0) && (r_left <= r_count)))
        else $error("dump counter outside the held entries");

    full_push_refused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (go && (i_head.kind == bdq_pkg::KIND_PUSH) && is_full)
            |=> ($stable(r_count) && $stable(r_fp)))
        else $error("push into a full queue changed the state");

    mid_run_only_in_dump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_last) |-> (r_state == S_DOUT))
        else $error("non-final result beat outside a dump");

endmodule

// ----- sv/bounded_deque_top.sv -----
`timescale 1ns / 1ps
// Bounded deque: commands are queued and each result is registered; a dump streams its
// elements through the store read and result registers. While results are taken, push,
// pop and bad codes go one per cycle, as do dump elements; the 2-entry queue lowers ready
// when full, as in a dump. Synchronous active-low reset clears pointers, count, queue and
// result valid; the element store keeps undefined contents until written.
// Depends on bdq_pkg, bdq_if, bdq_front and bdq_back.
module bounded_deque_top #(
    parameter int CAPACITY = bdq_pkg::CAPACITY_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bdq_cmd_if.sink   i_cmd,
    bdq_res_if.source o_res
);

    // decoded command at the head of the queue, handed front to back
    bdq_pkg::t_cmd head;
    logic          head_valid;
    logic          head_pop;

    // Front: decode func into a command class and buffer up to two beats,
    // so that a new command is taken while the back end streams a dump.
    bdq_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (i_cmd),
        .o_head       (head),
        .o_head_valid (head_valid),
        .i_head_pop   (head_pop)
    );

    // Back: owns the ring buffer (one write and one registered read per
    // cycle), front pointer and count; full/empty checks happen here as
    // they need the live count. Results go out through a single register
    // that can reload in the cycle its beat is taken.
    bdq_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_head_valid (head_valid),
        .o_head_pop   (head_pop),
        .o_res        (o_res)
    );

endmodule
